// ===== rtl/qkvt_pkg.sv =====
// Package for the quoted key/value tokenizer.
// Holds the configuration and result types, parse phase encoding and byte constants.
// No dependencies.
package qkvt_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'h22;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EQUALS      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_ENABLE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDING     = 8'd3;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] DELIMITER_RST = 8'd32;
    localparam logic [BYTE_W-1:0] EQUALS_RST    = 8'd61;
    localparam logic              PAD_EN_RST    = 1'b0;
    localparam logic [BYTE_W-1:0] PADDING_RST   = 8'd32;

    typedef enum logic [1:0] {
        PH_KEY   = 2'd0,
        PH_SKIP  = 2'd1,
        PH_VALUE = 2'd2,
        PH_DELIM = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] delimiter_char;
        logic [BYTE_W-1:0] equals_char;
        logic              padding_enable;
        logic [BYTE_W-1:0] padding_char;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] char_in;
        logic              is_final;
    } t_in_beat;

    typedef struct packed {
        logic              emit;
        logic              char_valid;
        logic [BYTE_W-1:0] char_out;
        logic              char_role;
        logic              pair_end;
        logic              string_end;
    } t_result;

endpackage

// ===== rtl/qkvt_cfg_regs.sv =====
// Configuration register file of the quoted key/value tokenizer.
// Depends on qkvt_pkg.
module qkvt_cfg_regs
    import qkvt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_char <= DELIMITER_RST;
            r_cfg.equals_char    <= EQUALS_RST;
            r_cfg.padding_enable <= PAD_EN_RST;
            r_cfg.padding_char   <= PADDING_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DELIMITER:  r_cfg.delimiter_char <= i_cfg_data;
                CFG_EQUALS:     r_cfg.equals_char    <= i_cfg_data;
                CFG_PAD_ENABLE: r_cfg.padding_enable <= i_cfg_data[0];
                CFG_PADDING:    r_cfg.padding_char   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/qkvt_in_reg.sv =====
// Input register of the quoted key/value tokenizer: holds one accepted beat.
// Depends on qkvt_pkg.
module qkvt_in_reg
    import qkvt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_char_in,
    input  logic              i_is_final,
    input  logic              i_take,
    output t_in_beat          o_beat
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_char;
    logic              r_final;
    logic              load;

    // Hold the beat until the step logic takes it
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char  <= i_char_in;
            r_final <= i_is_final;
        end
    end

    assign o_beat.valid    = r_valid;
    assign o_beat.char_in  = r_char;
    assign o_beat.is_final = r_final;

endmodule

// ===== rtl/qkvt_step.sv =====
// Per-byte parse logic of the quoted key/value tokenizer (combinational).
// Depends on qkvt_pkg.
module qkvt_step
    import qkvt_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_phase            i_phase,
    input  logic              i_in_quotes,
    input  logic [BYTE_W-1:0] i_char,
    input  logic              i_final,
    output t_phase            o_phase,
    output logic              o_in_quotes,
    output t_result           o_res
);

    logic   is_eq;
    logic   is_pad;
    logic   is_delim;
    logic   is_quote;
    t_phase ph_a;
    t_phase ph_b;
    t_phase ph_step;
    logic   quotes_step;
    logic   byte_valid;
    logic   byte_role;
    logic   pend;

    assign is_eq    = (i_char == i_cfg.equals_char);
    assign is_pad   = i_cfg.padding_enable && (i_char == i_cfg.padding_char);
    assign is_delim = (i_char == i_cfg.delimiter_char);
    assign is_quote = (i_char == QUOTE_BYTE);

    // Resolve the phase that actually handles this byte
    always_comb begin
        ph_a       = ((i_phase == PH_DELIM) && !is_delim) ? PH_KEY : i_phase;
        ph_b       = ((ph_a == PH_SKIP) && !is_eq && !is_pad && !is_delim) ? PH_VALUE : ph_a;
    end

    // Next state
    always_comb begin
        ph_step     = ph_b;
        quotes_step = i_in_quotes;
        unique case (ph_b)
            PH_KEY: begin
                if (is_eq) begin
                    ph_step = PH_SKIP;
                end else if (!i_in_quotes && is_pad) begin
                    ph_step = PH_SKIP;
                end else if (!i_in_quotes && is_delim) begin
                    ph_step = PH_DELIM;
                end else if (is_quote) begin
                    quotes_step = !i_in_quotes;
                end
            end
            PH_SKIP: begin
                if (!is_eq && !is_pad && is_delim) begin
                    ph_step = PH_DELIM;
                end
            end
            PH_VALUE: begin
                if (!i_in_quotes && is_delim) begin
                    ph_step = PH_DELIM;
                end else if (is_quote) begin
                    quotes_step = !i_in_quotes;
                end
            end
            PH_DELIM: ;
            default: ;
        endcase
        // End of string closes everything for the next string
        o_phase     = i_final ? PH_KEY : ph_step;
        o_in_quotes = i_final ? 1'b0 : quotes_step;
    end

    // Outputs
    always_comb begin
        byte_valid = 1'b0;
        byte_role  = 1'b0;
        pend       = 1'b0;
        unique case (ph_b)
            PH_KEY: begin
                if (is_eq || (!i_in_quotes && is_pad)) begin
                    pend = 1'b0;
                end else if (!i_in_quotes && is_delim) begin
                    pend = 1'b1;
                end else if (!is_quote) begin
                    byte_valid = 1'b1;
                end
            end
            PH_SKIP: begin
                pend = !is_eq && !is_pad && is_delim;
            end
            PH_VALUE: begin
                if (!i_in_quotes && is_delim) begin
                    pend = 1'b1;
                end else if (!is_quote) begin
                    byte_valid = 1'b1;
                    byte_role  = 1'b1;
                end
            end
            PH_DELIM: ;
            default: ;
        endcase
        if (i_final && (ph_step != PH_DELIM)) begin
            pend = 1'b1;
        end
        o_res.emit       = byte_valid || pend || i_final;
        o_res.char_valid = byte_valid;
        o_res.char_out   = byte_valid ? i_char : '0;
        o_res.char_role  = byte_valid && byte_role;
        o_res.pair_end   = pend;
        o_res.string_end = i_final;
    end

endmodule

// ===== rtl/quoted_key_value_tokenizer.sv =====
// Quoted key/value tokenizer, top level.
// Input channel: one string byte per beat on i_char_in, with i_is_final set on
// the last byte of a string. A beat is taken at a rising edge where i_in_valid
// is high and o_in_stall is low.
// Output channel: at most one result per input byte. A result carries a key or
// value byte (o_char_valid, o_char_out, o_char_role: 0 key, 1 value), a pair
// end flag and a string end flag. A beat moves at an edge where o_out_valid is
// high and i_out_stall is low. Bytes that are pure separators (equals,
// padding, repeated delimiters, quotes) produce no result unless they end a
// pair or the string.
// Configuration: write channel i_cfg_valid / o_cfg_ready (always ready) with
// i_cfg_index 0 delimiter, 1 equals, 2 padding enable, 3 padding byte; other
// indexes are ignored. Write only while the block is idle.
// Each byte passes through the input register, then the result register. Throughput:
// one byte per cycle while the output does not stall, set by the phase/quote
// state update between the two registers.
// Reset (synchronous, active low): registers return to their defaults, the
// parser returns to the key phase outside quotes, both registers empty.
// Output stall: the result holds; one more byte is taken into the input register,
// then o_in_stall stays high until the result beat moves.
module quoted_key_value_tokenizer
    import qkvt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // input byte channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_char_in,
    input  logic                 i_is_final,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_char_valid,
    output logic [BYTE_W-1:0]    o_char_out,
    output logic                 o_char_role,
    output logic                 o_pair_end,
    output logic                 o_string_end
);

    t_cfg     cfg;
    t_in_beat beat;
    t_phase   r_phase;
    t_phase   n_phase;
    logic     r_in_quotes;
    logic     n_in_quotes;
    t_result  res;
    t_result  r_out;
    logic     r_out_valid;
    logic     advance;

    qkvt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    qkvt_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_char_in  (i_char_in),
        .i_is_final (i_is_final),
        .i_take     (advance),
        .o_beat     (beat)
    );

    qkvt_step u_step (
        .i_cfg       (cfg),
        .i_phase     (r_phase),
        .i_in_quotes (r_in_quotes),
        .i_char      (beat.char_in),
        .i_final     (beat.is_final),
        .o_phase     (n_phase),
        .o_in_quotes (n_in_quotes),
        .o_res       (res)
    );

    // Process the held byte when the result register is free or draining
    assign advance = beat.valid && (!r_out_valid || !i_out_stall);

    // Parser state: advance only when a byte is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_KEY;
            r_in_quotes <= 1'b0;
        end else if (advance) begin
            r_phase     <= n_phase;
            r_in_quotes <= n_in_quotes;
        end
    end

    // Result register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_valid = r_out.char_valid;
    assign o_char_out   = r_out.char_out;
    assign o_char_role  = r_out.char_role;
    assign o_pair_end   = r_out.pair_end;
    assign o_string_end = r_out.string_end;

endmodule

// ===== bench/quoted_key_value_tokenizer_tb.sv =====
// Self-checking bench for the quoted key/value tokenizer.
// Drives byte strings, tracks expected key/value results, compares every result beat.
// Depends on rtl/qkvt_pkg.sv and rtl/quoted_key_value_tokenizer.sv.
`timescale 1ns / 1ps

module quoted_key_value_tokenizer_tb;
    import qkvt_pkg::*;

    // Common separator bytes used by the directed and random strings
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;

    // Index past the last register; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_PADDING + 8'd1;

    // Two-register pipeline; leave a few spare cycles after the last result
    localparam int unsigned PIPE_SLACK   = 6;
    localparam int unsigned DRAIN_LIMIT  = 20000;
    localparam int unsigned MAX_REPORTS  = 30;
    localparam int unsigned SEGMENT_BYTES = 104;

    typedef enum int unsigned {
        SEP_DEFAULT,
        SEP_COMMA,
        SEP_LINE,
        SEP_RANDOM,
        SEP_EXTREME,
        SEP_STYLES
    } t_sep_style;

    typedef struct packed {
        logic              char_valid;
        logic [BYTE_W-1:0] char_out;
        logic              role;
        logic              pair_end;
        logic              string_end;
    } t_tok_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_char_in = '0;
    logic                 i_is_final = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_char_valid;
    logic [BYTE_W-1:0]    o_char_out;
    logic                 o_char_role;
    logic                 o_pair_end;
    logic                 o_string_end;

    // Shadow of the block: separator registers, parse phase and quote flag
    t_cfg        cfg_shadow = '{DELIMITER_RST, EQUALS_RST, PAD_EN_RST, PADDING_RST};
    t_phase      parse_at = PH_KEY;
    logic        quoted = 1'b0;

    t_tok_result pending_tokens[$];
    t_tok_result head_token;
    logic [BYTE_W-1:0] line_buf[$];

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned fail_count = 0;

    quoted_key_value_tokenizer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_in    (i_char_in),
        .i_is_final   (i_is_final),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_char_valid (o_char_valid),
        .o_char_out   (o_char_out),
        .o_char_role  (o_char_role),
        .o_pair_end   (o_pair_end),
        .o_string_end (o_string_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver side: stall at random at the current rate
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Print the first few mismatches, count all of them
    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        if (fail_count < MAX_REPORTS)
            $display("qkvt mismatch @%0t: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Append one expectation at the tail of the result queue
    function automatic void queue_token(input t_tok_result r);
        pending_tokens.insert(pending_tokens.size(), r);
    endfunction

    // Append one byte at the tail of the line buffer
    function automatic void append_byte(input logic [BYTE_W-1:0] b);
        line_buf.insert(line_buf.size(), b);
    endfunction

    // Advance the shadow parser by one accepted byte and queue the result it causes.
    // Phases are tried in order; the delimiter and skip phases can hand the byte on to the next one.
    function automatic void tokenize_byte(input logic [BYTE_W-1:0] c, input logic fin);
        logic        is_pad;
        logic        taken;
        t_tok_result r;
        is_pad = cfg_shadow.padding_enable && (c == cfg_shadow.padding_char);
        taken = 1'b0;
        r = '0;

        // after a pair: swallow repeated delimiters, anything else starts a key
        if (parse_at == PH_DELIM) begin
            if (c == cfg_shadow.delimiter_char)
                taken = 1'b1;
            else
                parse_at = PH_KEY;
        end

        // key: equals always ends it; padding and delimiter only outside quotes
        if (!taken && parse_at == PH_KEY) begin
            taken = 1'b1;
            if (c == cfg_shadow.equals_char) begin
                parse_at = PH_SKIP;
            end else if (!quoted && is_pad) begin
                parse_at = PH_SKIP;
            end else if (!quoted && c == cfg_shadow.delimiter_char) begin
                r.pair_end = 1'b1;
                parse_at = PH_DELIM;
            end else if (c == QUOTE_BYTE) begin
                quoted = !quoted;
            end else begin
                r.char_valid = 1'b1;
            end
        end

        // between key and value: skip equals/padding regardless of quotes
        if (!taken && parse_at == PH_SKIP) begin
            if (c == cfg_shadow.equals_char || is_pad) begin
                taken = 1'b1;
            end else if (c == cfg_shadow.delimiter_char) begin
                taken = 1'b1;
                r.pair_end = 1'b1;
                parse_at = PH_DELIM;
            end else begin
                parse_at = PH_VALUE;
            end
        end

        // value runs to an unquoted delimiter
        if (!taken && parse_at == PH_VALUE) begin
            if (!quoted && c == cfg_shadow.delimiter_char) begin
                r.pair_end = 1'b1;
                parse_at = PH_DELIM;
            end else if (c == QUOTE_BYTE) begin
                quoted = !quoted;
            end else begin
                r.char_valid = 1'b1;
                r.role = 1'b1;
            end
        end

        // end of string closes any open pair and clears the parser
        if (fin) begin
            if (parse_at != PH_DELIM)
                r.pair_end = 1'b1;
            parse_at = PH_KEY;
            quoted = 1'b0;
        end

        if (r.char_valid)
            r.char_out = c;
        r.string_end = fin;
        if (r.char_valid || r.pair_end || fin)
            queue_token(r);
    endfunction

    // Result side: match every beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_tokens.size() == 0) begin
                report_mismatch("result with nothing pending, char", o_char_out, 8'h00);
            end else begin
                head_token = pending_tokens.pop_front();
                if (o_char_valid !== head_token.char_valid)
                    report_mismatch("char_valid", {7'd0, o_char_valid},
                                    {7'd0, head_token.char_valid});
                if (o_char_out !== head_token.char_out)
                    report_mismatch("char_out", o_char_out, head_token.char_out);
                if (o_char_role !== head_token.role)
                    report_mismatch("char_role", {7'd0, o_char_role},
                                    {7'd0, head_token.role});
                if (o_pair_end !== head_token.pair_end)
                    report_mismatch("pair_end", {7'd0, o_pair_end},
                                    {7'd0, head_token.pair_end});
                if (o_string_end !== head_token.string_end)
                    report_mismatch("string_end", {7'd0, o_string_end},
                                    {7'd0, head_token.string_end});
            end
        end
    end

    // Send one byte beat; idle first at the current gap rate. Valid stays high on
    // return so back-to-back beats never drop it for a single step.
    task automatic send_byte(input logic [BYTE_W-1:0] c, input logic fin);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        i_is_final <= fin;
        do @(posedge i_clk); while (o_in_stall);
        tokenize_byte(c, fin);
    endtask

    // Send the whole line buffer as one string, final flag on the last byte
    task automatic send_line();
        for (int unsigned i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    // Hold the sender until all results are in, then let the pipeline empty out
    task automatic settle_pipeline();
        int unsigned guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    // Write one register; valid is left high so the next write follows directly
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DELIMITER:  cfg_shadow.delimiter_char = data;
            CFG_EQUALS:     cfg_shadow.equals_char = data;
            CFG_PAD_ENABLE: cfg_shadow.padding_enable = data[0];
            CFG_PADDING:    cfg_shadow.padding_char = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] delim, input logic [BYTE_W-1:0] eq,
                              input logic pad_en, input logic [BYTE_W-1:0] pad);
        write_reg(CFG_DELIMITER, delim);
        write_reg(CFG_EQUALS, eq);
        write_reg(CFG_PAD_ENABLE, {7'd0, pad_en});
        write_reg(CFG_PADDING, pad);
        i_cfg_valid <= 1'b0;
    endtask

    // Any byte that is not a separator or a quote under the current settings
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do b = 8'($urandom_range(255));
        while (b == cfg_shadow.delimiter_char || b == cfg_shadow.equals_char ||
               b == QUOTE_BYTE ||
               (cfg_shadow.padding_enable && b == cfg_shadow.padding_char));
        return b;
    endfunction

    function automatic void push_run(input logic [BYTE_W-1:0] b, input int unsigned lo,
                                     input int unsigned hi);
        int unsigned n;
        n = $urandom_range(hi, lo);
        repeat (n) append_byte(b);
    endfunction

    // Key or value text; inside quotes mix in delimiter and padding bytes as data
    function automatic void push_text(input logic q, input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            if (q && $urandom_range(3) == 0)
                append_byte($urandom_range(1) ? cfg_shadow.delimiter_char
                                              : cfg_shadow.padding_char);
            else
                append_byte(plain_byte());
        end
    endfunction

    // Build a mostly well-formed string of pairs, sometimes with noise or open quotes
    function automatic void build_pairs_line();
        int unsigned n_pairs;
        logic        q;
        line_buf.delete();
        q = 1'b0;
        if ($urandom_range(7) == 0)
            push_run(cfg_shadow.delimiter_char, 1, 2);
        n_pairs = $urandom_range(4, 1);
        for (int unsigned p = 0; p < n_pairs; p++) begin
            if (p != 0)
                push_run(cfg_shadow.delimiter_char, 1, 3);
            if ($urandom_range(3) == 0) begin
                append_byte(QUOTE_BYTE);
                q = !q;
            end
            push_text(q, $urandom_range(4));
            if (q && $urandom_range(1)) begin
                append_byte(QUOTE_BYTE);
                q = 1'b0;
            end
            // most pairs carry a value; the rest end on a bare key
            if ($urandom_range(4) != 0) begin
                if (cfg_shadow.padding_enable)
                    push_run(cfg_shadow.padding_char, 0, 2);
                push_run(cfg_shadow.equals_char, 1, 2);
                if (cfg_shadow.padding_enable)
                    push_run(cfg_shadow.padding_char, 0, 2);
                if ($urandom_range(3) == 0) begin
                    append_byte(QUOTE_BYTE);
                    q = !q;
                end
                push_text(q, $urandom_range(5));
                if (q && $urandom_range(3) != 0) begin
                    append_byte(QUOTE_BYTE);
                    q = 1'b0;
                end
            end
        end
        if ($urandom_range(5) == 0)
            push_run(cfg_shadow.delimiter_char, 1, 2);
        // corrupt a few bytes now and then
        if ($urandom_range(3) == 0) begin
            foreach (line_buf[i])
                if ($urandom_range(19) == 0)
                    line_buf[i] = 8'($urandom_range(255));
        end
        if (line_buf.size() == 0)
            append_byte(plain_byte());
    endfunction

    // Pure noise string of any bytes
    function automatic void build_noise_line();
        int unsigned len;
        line_buf.delete();
        len = $urandom_range(12, 1);
        repeat (len) append_byte(8'($urandom_range(255)));
    endfunction

    task automatic apply_sep_style(input t_sep_style style);
        case (style)
            SEP_DEFAULT: set_config(CH_SPACE, CH_EQ, 1'($urandom_range(1)), CH_SPACE);
            SEP_COMMA:   set_config(CH_COMMA, CH_EQ, 1'b1, CH_SPACE);
            SEP_LINE:    set_config(CH_NL, CH_SEMI, 1'($urandom_range(1)), CH_COMMA);
            SEP_RANDOM:  set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                    1'($urandom_range(1)), 8'($urandom_range(255)));
            default:     set_config($urandom_range(1) ? 8'hFF : 8'h00,
                                    $urandom_range(1) ? 8'hFF : 8'h00,
                                    1'($urandom_range(1)),
                                    $urandom_range(1) ? 8'hFF : 8'h00);
        endcase
    endtask

    // Keep sending strings until the byte budget is spent; optionally pause once
    // halfway and let every outstanding result come back first
    task automatic run_segment(input int unsigned budget, input logic pause_midway);
        int unsigned sent;
        logic        paused;
        sent = 0;
        paused = 1'b0;
        while (sent < budget) begin
            if ($urandom_range(7) == 0)
                build_noise_line();
            else
                build_pairs_line();
            send_line();
            sent += line_buf.size();
            if (pause_midway && !paused && sent >= budget / 2) begin
                settle_pipeline();
                paused = 1'b1;
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Leading delimiter gives an empty pair; bare keys end with an empty value;
    // delimiter runs are skipped; a delimiter as the final byte
    task automatic test_leading_delimiter();
        line_buf = '{CH_SPACE, "k", CH_EQ, "v"};
        send_line();
        line_buf = '{"k", CH_SPACE, CH_SPACE, "x"};
        send_line();
        line_buf = '{"a", CH_SPACE};
        send_line();
    endtask

    // Quote carries across the equals byte into the value and is never closed,
    // so the spaces inside stay data and the value runs to the end
    task automatic test_quoted_text();
        line_buf = '{QUOTE_BYTE, "a", CH_SPACE, CH_EQ, "b", CH_SPACE, "c"};
        send_line();
    endtask

    task automatic test_char_extremes();
        line_buf = '{8'h00, 8'hFF};
        send_line();
    endtask

    // Padding equal to the quote byte, byte extremes as separators, and a write
    // to an index the block must ignore
    task automatic test_separator_collisions();
        settle_pipeline();
        write_reg(CFG_SPARE, 8'hA5);
        set_config(8'h00, 8'hFF, 1'b1, QUOTE_BYTE);
        line_buf = '{"a", QUOTE_BYTE, 8'hFF, QUOTE_BYTE, "b", 8'h00, "c"};
        send_line();
    endtask

    task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                       input logic pause_midway, input int unsigned rot);
        gap_pct = gap;
        stall_pct = stall;
        for (int unsigned k = 0; k < 3; k++) begin
            settle_pipeline();
            apply_sep_style(t_sep_style'((rot + k) % SEP_STYLES));
            run_segment(SEGMENT_BYTES, pause_midway && k == 1);
        end
    endtask

    // Hard stop in case the block hangs
    initial begin
        #400_000;
        $display("quoted_key_value_tokenizer_tb: errors");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_leading_delimiter();
        test_quoted_text();
        test_char_extremes();
        test_separator_collisions();

        test_random_traffic(0, 0, 1'b0, 0);
        test_random_traffic(60, 0, 1'b0, 1);
        test_random_traffic(0, 60, 1'b1, 2);
        test_random_traffic(10, 10, 1'b0, 3);

        settle_pipeline();
        while (pending_tokens.size() != 0) begin
            report_mismatch("result never arrived, char", 8'h00, pending_tokens[0].char_out);
            void'(pending_tokens.pop_front());
        end

        if (fail_count == 0)
            $display("quoted_key_value_tokenizer_tb: clean");
        else
            $display("quoted_key_value_tokenizer_tb: errors");
        $finish;
    end

endmodule
